/* hw/rtl/pss_pkg.sv */
`default_nettype none

package pss_pkg;

   localparam int FREQ_W  = 24;
   localparam int ENTRY_W = 23;
   localparam int IDX_W   = 4;
   localparam int COUNT_W = 5;
   localparam int PROD_W  = 2 * ENTRY_W;
   localparam int DATA_W  = 32;
   localparam int REQ_PAD_W = DATA_W - IDX_W - FREQ_W;
   localparam int RSP_PAD_W = DATA_W - FREQ_W - IDX_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SNAP = 1'b1;

   typedef struct packed {
      logic accept_load;
      logic accept_snap;
      logic mul;
      logic cmp;
      logic out_load;
   } pss_cmd_type;

   typedef struct packed {
      logic snap_op;
      logic direct;
      logic cand_last;
      logic out_busy;
   } pss_status_type;

endpackage

`default_nettype wire

/* hw/rtl/pss_ctrl.sv */
`default_nettype none

module pss_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire pss_pkg::pss_status_type status,
   output pss_pkg::pss_cmd_type         cmd
);
   import pss_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (status.snap_op == OP_SNAP) begin
                  cmd.accept_snap = 1'b1;
                  // non-positive input or empty scale needs no search
                  state_in = status.direct ? ST_FINISH : ST_READ;
               end else begin
                  cmd.accept_load = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = status.cand_last ? ST_FINISH : ST_MUL;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pss_datapath.sv */
`default_nettype none

module pss_datapath #(
   parameter int SCALE_DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [pss_pkg::COUNT_W-1:0]  csr_wr_data,
   input  wire logic [pss_pkg::DATA_W-1:0]   req_tdata,
   input  wire logic                         req_tuser,
   input  wire logic                         req_tlast,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [pss_pkg::DATA_W-1:0]        rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  wire pss_pkg::pss_cmd_type         cmd,
   output pss_pkg::pss_status_type           status
);
   import pss_pkg::*;

   localparam int ADDR_W = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SCALE_DEPTH + 1);

   logic [IDX_W-1:0]   req_idx;
   logic [FREQ_W-1:0]  req_freq;
   logic               req_pos;
   logic [CNT_W-1:0]   n_in;

   logic [COUNT_W-1:0] count_ff;

   logic [ENTRY_W-1:0] mem [SCALE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [FREQ_W-1:0]  f_ff;
   logic               pos_ff;
   logic               last_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   j_ff;
   logic               is_last;

   logic [ENTRY_W-1:0] fu;
   logic [ENTRY_W-1:0] hi_in;
   logic [ENTRY_W-1:0] lo_in;
   logic [PROD_W-1:0]  prod_a_in;
   logic [PROD_W-1:0]  prod_b_in;

   logic [PROD_W-1:0]  prod_a_ff;
   logic [PROD_W-1:0]  prod_b_ff;
   logic [ENTRY_W-1:0] cand_hi_ff;
   logic [ENTRY_W-1:0] cand_lo_ff;
   logic [ENTRY_W-1:0] cand_s_ff;
   logic [ADDR_W-1:0]  cand_idx_ff;
   logic               cand_last_ff;

   logic [ENTRY_W-1:0] best_hi_ff;
   logic [ENTRY_W-1:0] best_lo_ff;
   logic [ENTRY_W-1:0] best_s_ff;
   logic [ADDR_W-1:0]  best_idx_ff;
   logic               found_ff;
   logic               take;

   logic               rsp_valid_ff;
   logic [FREQ_W-1:0]  out_freq_ff;
   logic [IDX_W-1:0]   out_idx_ff;
   logic               out_matched_ff;
   logic               out_last_ff;
   logic [FREQ_W-1:0]  out_freq_in;
   logic [IDX_W-1:0]   out_idx_in;

   assign req_idx  = req_tdata[IDX_W-1:0];
   assign req_freq = req_tdata[IDX_W +: FREQ_W];
   assign req_pos  = !req_freq[FREQ_W-1] && (req_freq != '0);

   // saturate the entry count to the table depth
   assign n_in = (32'(count_ff) > SCALE_DEPTH) ? CNT_W'(SCALE_DEPTH) : CNT_W'(count_ff);

   assign status.snap_op   = req_tuser;
   assign status.direct    = !req_pos || (n_in == '0);
   assign status.cand_last = cand_last_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // scale table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept_load && (32'(req_idx) < SCALE_DEPTH)) begin
         mem[ADDR_W'(req_idx)] <= req_pos ? req_freq[ENTRY_W-1:0] : '0;
      end
      rd_data_ff <= mem[j_ff[ADDR_W-1:0]];
   end

   assign is_last = (j_ff == (n_ff - CNT_W'(1)));

   assign fu        = f_ff[ENTRY_W-1:0];
   assign hi_in     = (rd_data_ff > fu) ? rd_data_ff : fu;
   assign lo_in     = (rd_data_ff > fu) ? fu : rd_data_ff;
   assign prod_a_in = PROD_W'(hi_in) * PROD_W'(best_lo_ff);
   assign prod_b_in = PROD_W'(best_hi_ff) * PROD_W'(lo_in);

   // strict less-than keeps the earlier entry on a tie
   assign take = (cand_s_ff != '0) && (!found_ff || (prod_a_ff < prod_b_ff));

   always_ff @(posedge clock) begin
      if (cmd.accept_snap) begin
         f_ff    <= req_freq;
         pos_ff  <= req_pos;
         last_ff <= req_tlast;
         n_ff    <= n_in;
      end
      if (cmd.mul) begin
         prod_a_ff    <= prod_a_in;
         prod_b_ff    <= prod_b_in;
         cand_hi_ff   <= hi_in;
         cand_lo_ff   <= lo_in;
         cand_s_ff    <= rd_data_ff;
         cand_idx_ff  <= j_ff[ADDR_W-1:0];
         cand_last_ff <= is_last;
      end
      if (cmd.cmp && take) begin
         best_hi_ff  <= cand_hi_ff;
         best_lo_ff  <= cand_lo_ff;
         best_s_ff   <= cand_s_ff;
         best_idx_ff <= cand_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff     <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.accept_snap) begin
            j_ff     <= '0;
            found_ff <= 1'b0;
         end else begin
            // advance the read address, but never past the last entry
            if (cmd.mul && !is_last) begin
               j_ff <= j_ff + CNT_W'(1);
            end
            if (cmd.cmp && take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (!pos_ff) begin
         out_freq_in = f_ff;
         out_idx_in  = '0;
      end else if (found_ff) begin
         out_freq_in = FREQ_W'(best_s_ff);
         out_idx_in  = IDX_W'(best_idx_ff);
      end else begin
         out_freq_in = '0;
         out_idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_freq_ff    <= out_freq_in;
         out_idx_ff     <= out_idx_in;
         out_matched_ff <= pos_ff && found_ff;
         out_last_ff    <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_idx_ff, out_freq_ff};
   assign rsp_tuser  = out_matched_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/pitch_snap_to_scale.sv */
// Load items are accepted back to back, one per cycle.
// A snap item searching n entries (n = scale_count saturated to SCALE_DEPTH) goes
// through one table read, then a multiply and a compare step per entry, then waits
// until the output register is free; no new item is taken before its result is loaded.
// Non-positive input or an empty scale skips the search and goes straight to that wait.
// Reset clears the controller, scale_count and the output valid; the table is not cleared.
`default_nettype none

module pitch_snap_to_scale #(
   parameter int SCALE_DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [pss_pkg::COUNT_W-1:0]  csr_wr_data,   // scale_count
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [pss_pkg::DATA_W-1:0]   req_tdata,     // entry_index[3:0], frequency[27:4]
   input  wire logic                         req_tuser,     // opcode
   input  wire logic                         req_tlast,     // last_frequency
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [pss_pkg::DATA_W-1:0]        rsp_tdata,     // snapped_frequency[23:0],
                                                            // matched_entry[27:24]
   output logic                              rsp_tuser,     // matched
   output logic                              rsp_tlast      // last_result
);
   import pss_pkg::*;

   pss_cmd_type    cmd;
   pss_status_type status;

   pss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pss_datapath #(
      .SCALE_DEPTH (SCALE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

/* hw/rtl/pss_checker.sv */
`default_nettype none

module pss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // nothing is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an unmatched result carries entry zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[27:24] == 4'd0)
      else $error("unmatched result with non-zero entry");

   // a matched result is a positive scale value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[23] && (rsp_tdata[23:0] != 24'd0))
      else $error("matched result not positive");

   // a load item gives no result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after load item");

endmodule

bind pitch_snap_to_scale pss_checker u_pss_checker (.*);

`default_nettype wire

/* verif/tb_pitch_snap_to_scale.sv */
`default_nettype none

module tb_pitch_snap_to_scale;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int DEPTH          = 16;
   localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 4;
   localparam int SEGMENTS       = 8;
   localparam int SEGMENT_ITEMS  = 52;
   localparam int MAX_FREQ       = 8388607;

   typedef struct packed {
      logic [FREQ_W-1:0] snapped;
      logic [IDX_W-1:0]  entry;
      logic              matched;
      logic              last;
   } snap_result_type;

   typedef struct packed {
      logic                     set_count;
      logic [COUNT_W-1:0]       count;
      logic                     op;
      logic [IDX_W-1:0]         idx;
      logic signed [FREQ_W-1:0] freq;
      logic                     last;
      logic                     pinned;
      snap_result_type          want;
   } stim_row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]     csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata   = '0;
   logic                   req_tuser   = OP_LOAD;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   logic                   pin_active  = 1'b0;
   snap_result_type        pin_want    = '0;

   logic [ENTRY_W-1:0]     scale_notes [DEPTH];
   logic [COUNT_W-1:0]     note_count  = '0;
   snap_result_type        pending_snaps [$];
   stim_row_type           plan [$];
   int                     mismatches  = 0;
   int                     quiet_cycles = 0;
   int                     gap_pct     = 0;
   int                     stall_pct   = 0;

   pitch_snap_to_scale #(
      .SCALE_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Nearest entry in log distance: compare hi/lo ratios by cross-multiplying.
   function automatic snap_result_type nearest_note(logic signed [FREQ_W-1:0] pitch,
                                                    logic last);
      snap_result_type   r;
      longint unsigned   fu, s, hi, lo, best_hi, best_lo;
      int                n;
      r = '0;
      r.last = last;
      if (pitch <= 0) begin
         r.snapped = pitch;
      end else begin
         fu = longint'(pitch);
         best_hi = 0;
         best_lo = 1;
         n = (note_count > DEPTH) ? DEPTH : int'(note_count);
         for (int j = 0; j < n; j++) begin
            s = longint'(scale_notes[j]);
            if (s == 0)
               continue;
            hi = (s > fu) ? s : fu;
            lo = (s > fu) ? fu : s;
            if (!r.matched || hi * best_lo < best_hi * lo) begin
               r.matched = 1'b1;
               r.entry   = IDX_W'(j);
               r.snapped = FREQ_W'(s);
               best_hi   = hi;
               best_lo   = lo;
            end
         end
      end
      return r;
   endfunction

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   // Track the block's state at each handshake and check results in order.
   always @(posedge clock) begin
      snap_result_type got, want;
      logic signed [FREQ_W-1:0] f;
      if (!reset) begin
         if (csr_wr_en)
            note_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            f = req_tdata[IDX_W +: FREQ_W];
            if (req_tuser == OP_LOAD)
               scale_notes[req_tdata[IDX_W-1:0]] = (f > 0) ? f[ENTRY_W-1:0] : '0;
            else
               pending_snaps.push_back(pin_active ? pin_want : nearest_note(f, req_tlast));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.snapped = rsp_tdata[FREQ_W-1:0];
            got.entry   = rsp_tdata[FREQ_W +: IDX_W];
            got.matched = rsp_tuser;
            got.last    = rsp_tlast;
            if (pending_snaps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: snapped=%h entry=%0d matched=%b last=%b",
                           got.snapped, got.entry, got.matched, got.last);
            end else begin
               want = pending_snaps.pop_front();
               if (got.snapped !== want.snapped || got.entry !== want.entry ||
                   got.matched !== want.matched || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected snapped=%h entry=%0d matched=%b last=%b,",
                               " got snapped=%h entry=%0d matched=%b last=%b"},
                              want.snapped, want.entry, want.matched, want.last,
                              got.snapped, got.entry, got.matched, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[pitch_snap_to_scale] ERROR");
         $finish;
      end
   end

   // Entered and left at a falling edge.
   task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [FREQ_W-1:0] freq,
                            logic last, logic pin, snap_result_type want);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, freq, idx};
      req_tlast  <= last;
      pin_active <= pin;
      pin_want   <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold off until every result is back and any load has settled.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_snaps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_note_count(logic [COUNT_W-1:0] value);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic add_row(logic set_count, logic [COUNT_W-1:0] count, logic op,
                          logic [IDX_W-1:0] idx, logic signed [FREQ_W-1:0] freq, logic last,
                          logic pinned, snap_result_type want);
      stim_row_type r;
      r.set_count = set_count;
      r.count     = count;
      r.op        = op;
      r.idx       = idx;
      r.freq      = freq;
      r.last      = last;
      r.pinned    = pinned;
      r.want      = want;
      plan.push_back(r);
   endtask

   function automatic logic signed [FREQ_W-1:0] random_note();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60)
         return FREQ_W'($urandom_range(20 * 256, 2000 * 256));
      else if (k < 85)
         return FREQ_W'($urandom_range(1, MAX_FREQ));
      else if (k < 92)
         return '0;
      else
         return FREQ_W'($urandom);
   endfunction

   function automatic logic signed [FREQ_W-1:0] random_pitch();
      int k, base, off;
      k = $urandom_range(0, 99);
      if (k < 78) begin
         // land near a stored note so that neighbours compete
         base = int'(scale_notes[$urandom_range(0, DEPTH - 1)]);
         if (base == 0)
            base = $urandom_range(1, MAX_FREQ);
         off = $urandom_range(0, base / 8 + 1);
         base = $urandom_range(0, 1) ? base + off : base - off;
         if (base > MAX_FREQ)
            base = MAX_FREQ;
         if (base < 1)
            base = 1;
         return FREQ_W'(base);
      end else if (k < 88) begin
         return FREQ_W'($urandom);
      end else if (k < 94) begin
         return FREQ_W'(-$urandom_range(0, 2));
      end else begin
         return FREQ_W'($urandom_range(1, MAX_FREQ));
      end
   endfunction

   function automatic logic [COUNT_W-1:0] segment_count(int seg);
      case (seg % 8)
         0: return COUNT_W'(DEPTH);
         1: return '0;
         2: return '1;
         3: return COUNT_W'(1);
         4: return COUNT_W'($urandom_range(2, DEPTH - 1));
         5: return COUNT_W'($urandom_range(DEPTH + 1, 30));
         6: return COUNT_W'(DEPTH);
         default: return COUNT_W'($urandom_range(1, DEPTH));
      endcase
   endfunction

   initial begin
      stim_row_type             r;
      logic signed [FREQ_W-1:0] f;
      snap_result_type          none;
      none = '0;

      // empty scale straight after reset, then passthrough of non-positive pitches
      add_row(0, 0, OP_SNAP, 0, 24'sd256000, 0, 1, '{24'h000000, 4'd0, 1'b0, 1'b0});
      add_row(0, 0, OP_SNAP, 0, -24'sd1, 1, 1, '{24'hFFFFFF, 4'd0, 1'b0, 1'b1});
      add_row(0, 0, OP_SNAP, 15, 24'h800000, 0, 1, '{24'h800000, 4'd0, 1'b0, 1'b0});
      add_row(0, 0, OP_SNAP, 0, 24'sd0, 1, 1, '{24'h000000, 4'd0, 1'b0, 1'b1});
      // non-positive notes are stored as zero and never chosen
      add_row(0, 0, OP_LOAD, 0, -24'sd5, 0, 0, none);
      add_row(0, 0, OP_LOAD, 1, 24'sd0, 1, 0, none);
      add_row(0, 0, OP_LOAD, 2, 24'sd8388607, 0, 0, none);
      add_row(0, 0, OP_LOAD, 3, 24'sd1, 0, 0, none);
      add_row(0, 0, OP_LOAD, 4, 24'sd112640, 0, 0, none);
      add_row(0, 0, OP_LOAD, 5, 24'sd112640, 0, 0, none);
      add_row(0, 0, OP_LOAD, 6, 24'sd4, 0, 0, none);
      add_row(0, 0, OP_LOAD, 15, 24'sd56320, 1, 0, none);
      // only zero entries in range
      add_row(1, 2, OP_SNAP, 0, 24'sd256000, 1, 1, '{24'h000000, 4'd0, 1'b0, 1'b1});
      add_row(1, 7, OP_SNAP, 9, 24'sd1, 0, 0, none);
      add_row(0, 0, OP_SNAP, 0, 24'sd8388607, 1, 0, none);
      // equal notes: the lower entry wins
      add_row(0, 0, OP_SNAP, 0, 24'sd112640, 0, 0, none);
      // 2 sits exactly between 1 and 4 in log distance
      add_row(0, 0, OP_SNAP, 0, 24'sd2, 0, 0, none);
      add_row(0, 0, OP_SNAP, 0, 24'sd100000, 1, 0, none);
      add_row(0, 0, OP_SNAP, 0, 24'sd3000, 0, 0, none);
      add_row(1, 0, OP_SNAP, 0, 24'sd256000, 0, 1, '{24'h000000, 4'd0, 1'b0, 1'b0});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         r = plan[i];
         if (r.set_count)
            set_note_count(r.count);
         send_item(r.op, r.idx, r.freq, r.last, r.pinned, r.want);
      end

      // fill the whole table before any wider search
      for (int j = 0; j < DEPTH; j++)
         send_item(OP_LOAD, IDX_W'(j), random_note(), 1'($urandom), 0, none);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 75; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 75; end
            default: begin gap_pct = 21; stall_pct = 21; end
         endcase
         for (int s = 0; s < SEGMENTS; s++) begin
            set_note_count(segment_count(p * SEGMENTS + s));
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
               if ($urandom_range(0, 99) < 12) begin
                  send_item(OP_LOAD, IDX_W'($urandom), random_note(), 1'($urandom), 0, none);
               end else begin
                  f = random_pitch();
                  send_item(OP_SNAP, IDX_W'($urandom), f, 1'($urandom), 0, none);
               end
            end
         end
      end

      drain_block();
      if (mismatches == 0)
         $display("[pitch_snap_to_scale] OK");
      else
         $display("[pitch_snap_to_scale] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
